>>> hdl/bps_pkg.sv
// Shared types, codes and limits for the beep pattern sequencer.
package bps_pkg;

	// Request opcodes
	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_STOP    = 2'd1,
		OP_TONE    = 2'd2,
		OP_PATTERN = 2'd3
	} op_t;

	// Result codes
	typedef enum logic [1:0] {
		RC_OK        = 2'd0,
		RC_BAD_STATE = 2'd1,
		RC_BAD_ARG   = 2'd2
	} rc_t;

	// Playback phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ON   = 2'd1,
		PH_GAP  = 2'd2
	} phase_t;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_FB_FREQ  = 3'd1;
	localparam logic [2:0] REG_FB_ON    = 3'd2;
	localparam logic [2:0] REG_FB_GAP   = 3'd3;
	localparam logic [2:0] REG_FB_DUTY  = 3'd4;

	localparam int APB_ADDR_W  = 5;
	localparam int APB_DATA_W  = 32;

	// Register reset values
	localparam logic [14:0] FB_FREQ_RST = 15'd2000;
	localparam logic [15:0] FB_ON_RST   = 16'd100;
	localparam logic [15:0] FB_GAP_RST  = 16'd100;
	localparam logic [6:0]  FB_DUTY_RST = 7'd50;

	// Valid ranges
	localparam logic [15:0] FREQ_MIN = 16'd100;
	localparam logic [15:0] FREQ_MAX = 16'd20000;
	localparam logic [15:0] TIME_MIN = 16'd10;
	localparam logic [15:0] TIME_MAX = 16'd60000;
	localparam logic [7:0]  DUTY_MIN = 8'd1;
	localparam logic [7:0]  DUTY_MAX = 8'd90;

	// Divide by 100 as multiply by rounded-up reciprocal; exact for x < 2^35/3200
	localparam int          DIV_SHIFT  = 35;
	localparam int          DIV_MULT_W = 29;
	localparam logic [DIV_MULT_W-1:0] DIV_MULT =
		DIV_MULT_W'((64'd1 << DIV_SHIFT) / 100 + 1);

	localparam int LEVEL_W = 10;

	// Configuration registers
	typedef struct packed {
		logic        enable;
		logic [14:0] fb_freq;
		logic [15:0] fb_on;
		logic [15:0] fb_gap;
		logic [6:0]  fb_duty;
	} cfg_t;

	// Resolved and checked command
	typedef struct packed {
		rc_t         code;
		logic [14:0] freq;
		logic [6:0]  duty;
		logic [15:0] on_time;
		logic [15:0] gap;
		logic [7:0]  cycles;
		logic        repeating;
	} cmd_t;

	// One result
	typedef struct packed {
		rc_t                code;
		logic               sounding;
		logic [14:0]        freq;
		logic [6:0]         duty;
		logic [LEVEL_W-1:0] level;
	} res_t;

endpackage

>>> hdl/bps_regs.sv
// APB configuration registers for the beep pattern sequencer.
module bps_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bps_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bps_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bps_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output bps_pkg::cfg_t                  cfg
);
	import bps_pkg::*;

	logic [2:0] idx;
	logic       wr;
	cfg_t       cfg_q;

	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable  <= 1'b0;
			cfg_q.fb_freq <= FB_FREQ_RST;
			cfg_q.fb_on   <= FB_ON_RST;
			cfg_q.fb_gap  <= FB_GAP_RST;
			cfg_q.fb_duty <= FB_DUTY_RST;
		end else if (wr) begin
			unique case (idx)
				REG_ENABLE:  cfg_q.enable  <= pwdata[0];
				REG_FB_FREQ: cfg_q.fb_freq <= pwdata[14:0];
				REG_FB_ON:   cfg_q.fb_on   <= pwdata[15:0];
				REG_FB_GAP:  cfg_q.fb_gap  <= pwdata[15:0];
				REG_FB_DUTY: cfg_q.fb_duty <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_ENABLE:  prdata = APB_DATA_W'(cfg_q.enable);
			REG_FB_FREQ: prdata = APB_DATA_W'(cfg_q.fb_freq);
			REG_FB_ON:   prdata = APB_DATA_W'(cfg_q.fb_on);
			REG_FB_GAP:  prdata = APB_DATA_W'(cfg_q.fb_gap);
			REG_FB_DUTY: prdata = APB_DATA_W'(cfg_q.fb_duty);
			default:     prdata = '0;
		endcase
	end

endmodule

>>> hdl/bps_cmd.sv
// Command decode: default substitution, range checks and PWM level.
module bps_cmd #(
	parameter int PWM_BITS = 10
) (
	input  bps_pkg::op_t                 op,
	input  logic [15:0]                  tone_freq,
	input  logic [15:0]                  on_time,
	input  logic [15:0]                  gap_time,
	input  logic [7:0]                   repeats,
	input  logic [7:0]                   duty_percent,
	input  bps_pkg::cfg_t                cfg,
	output bps_pkg::cmd_t                cmd,
	output logic [bps_pkg::LEVEL_W-1:0]  level
);
	import bps_pkg::*;

	localparam int PROD_W = PWM_BITS + 8;
	localparam int MUL_W  = PROD_W + DIV_MULT_W;
	localparam int Q_W    = MUL_W - DIV_SHIFT;

	logic [15:0]       f, on, gap;
	logic [7:0]        d;
	logic              pattern, bad;
	logic [PROD_W-1:0] prod;
	logic [MUL_W-1:0]  mul;
	logic [Q_W-1:0]    q, lvl;

	// Zero freq, time and duty fields take the fallback registers
	assign f   = (tone_freq == '0) ? 16'(cfg.fb_freq) : tone_freq;
	assign on  = (on_time == '0) ? cfg.fb_on : on_time;
	assign gap = (gap_time == '0) ? cfg.fb_gap : gap_time;
	assign d   = (duty_percent == '0) ? 8'(cfg.fb_duty) : duty_percent;

	assign pattern = (op == OP_PATTERN);

	// Range checks
	assign bad = (f < FREQ_MIN) || (f > FREQ_MAX)
		|| (on < TIME_MIN) || (on > TIME_MAX)
		|| (d < DUTY_MIN) || (d > DUTY_MAX)
		|| (pattern && ((repeats == '0) || (gap < TIME_MIN) || (gap > TIME_MAX)));

	// Disabled takes precedence over a bad argument
	assign cmd.code = !cfg.enable ? RC_BAD_STATE : (bad ? RC_BAD_ARG : RC_OK);

	assign cmd.freq      = f[14:0];
	assign cmd.duty      = d[6:0];
	assign cmd.on_time   = on;
	assign cmd.gap       = pattern ? gap : '0;
	assign cmd.cycles    = pattern ? repeats - 8'd1 : '0;
	assign cmd.repeating = pattern;

	// Level = full*d/100, floor of 1, kept to the output width
	assign prod  = (PROD_W'(d) << PWM_BITS) - PROD_W'(d);
	assign mul   = MUL_W'(prod) * MUL_W'(DIV_MULT);
	assign q     = mul[MUL_W-1:DIV_SHIFT];
	assign lvl   = (q == '0) ? Q_W'(1) : q;
	assign level = lvl[LEVEL_W-1:0];

endmodule

>>> hdl/bps_seq.sv
// Playback state machine: phase, countdown and held tone settings.
module bps_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  bps_pkg::op_t                 op,
	input  bps_pkg::cmd_t                cmd,
	input  logic [bps_pkg::LEVEL_W-1:0]  level,
	input  logic                         enable,
	output bps_pkg::res_t                res
);
	import bps_pkg::*;

	phase_t              phase_q, phase_d;
	logic [15:0]         time_left_q, time_left_d;
	logic [7:0]          cycles_left_q, cycles_left_d;
	logic [14:0]         held_freq_q, held_freq_d;
	logic [6:0]          held_duty_q, held_duty_d;
	logic [15:0]         held_on_q, held_on_d;
	logic [15:0]         held_gap_q, held_gap_d;
	logic                repeating_q, repeating_d;
	logic [LEVEL_W-1:0]  held_level_q, held_level_d;

	// Next state
	always_comb begin
		phase_d       = phase_q;
		time_left_d   = time_left_q;
		cycles_left_d = cycles_left_q;
		held_freq_d   = held_freq_q;
		held_duty_d   = held_duty_q;
		held_on_d     = held_on_q;
		held_gap_d    = held_gap_q;
		repeating_d   = repeating_q;
		held_level_d  = held_level_q;
		unique case (op)
			OP_TICK: begin
				unique case (phase_q)
					PH_ON: begin
						if (time_left_q > 16'd1) begin
							time_left_d = time_left_q - 16'd1;
						end else if (repeating_q && (cycles_left_q != '0)) begin
							phase_d     = PH_GAP;
							time_left_d = held_gap_q;
						end else begin
							phase_d       = PH_IDLE;
							time_left_d   = '0;
							cycles_left_d = '0;
						end
					end
					PH_GAP: begin
						if (time_left_q > 16'd1) begin
							time_left_d = time_left_q - 16'd1;
						end else if (enable) begin
							// next on period
							phase_d       = PH_ON;
							time_left_d   = held_on_q;
							cycles_left_d = cycles_left_q - 8'd1;
						end else begin
							phase_d       = PH_IDLE;
							time_left_d   = '0;
							cycles_left_d = '0;
						end
					end
					default: ;
				endcase
			end
			OP_STOP: begin
				phase_d       = PH_IDLE;
				time_left_d   = '0;
				cycles_left_d = '0;
			end
			OP_TONE, OP_PATTERN: begin
				// rejected commands leave playback alone
				if (cmd.code == RC_OK) begin
					phase_d       = PH_ON;
					time_left_d   = cmd.on_time;
					cycles_left_d = cmd.cycles;
					held_freq_d   = cmd.freq;
					held_duty_d   = cmd.duty;
					held_on_d     = cmd.on_time;
					held_gap_d    = cmd.gap;
					repeating_d   = cmd.repeating;
					held_level_d  = level;
				end
			end
			default: ;
		endcase
	end

	// Result for this request
	always_comb begin
		res.code     = ((op == OP_TONE) || (op == OP_PATTERN)) ? cmd.code : RC_OK;
		res.sounding = (phase_d == PH_ON);
		res.freq     = res.sounding ? held_freq_d : '0;
		res.duty     = res.sounding ? held_duty_d : '0;
		res.level    = res.sounding ? held_level_d : '0;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			time_left_q   <= '0;
			cycles_left_q <= '0;
			held_freq_q   <= '0;
			held_duty_q   <= '0;
			held_on_q     <= '0;
			held_gap_q    <= '0;
			repeating_q   <= 1'b0;
			held_level_q  <= '0;
		end else if (adv) begin
			phase_q       <= phase_d;
			time_left_q   <= time_left_d;
			cycles_left_q <= cycles_left_d;
			held_freq_q   <= held_freq_d;
			held_duty_q   <= held_duty_d;
			held_on_q     <= held_on_d;
			held_gap_q    <= held_gap_d;
			repeating_q   <= repeating_d;
			held_level_q  <= held_level_d;
		end
	end

`ifndef SYNTHESIS
	a_reject_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ((op == OP_TONE) || (op == OP_PATTERN)) && (cmd.code != RC_OK)
		|=> $stable(phase_q) && $stable(held_freq_q) && $stable(time_left_q))
		else $error("rejected command changed playback state");

	a_gap_needs_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_GAP) |-> repeating_q)
		else $error("gap phase without a pattern");

	a_active_duty_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (held_duty_q != '0) && (held_duty_q <= 7'd90))
		else $error("active playback with unchecked duty");
`endif

endmodule

>>> hdl/beep_pattern_sequencer.sv
// An accepted request waits in the input stage until the result register is free or draining.
// The input stage refills while the result register drains; res_stall holds both stages.
// Throughput: one request per cycle while res_stall is low.
// Each request costs one pass of decode, range check and the divide-by-100 multiplier.
// Reset: arst_n clears the pipeline, playback goes idle, registers take their defaults.
// Buzzer is disabled after reset until the enable register is written.
module beep_pattern_sequencer #(
	parameter int PWM_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [1:0]                     op,
	input  logic [15:0]                    tone_freq,
	input  logic [15:0]                    on_time,
	input  logic [15:0]                    gap_time,
	input  logic [7:0]                     repeats,
	input  logic [7:0]                     duty_percent,
	// result channel
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [1:0]                     result_code,
	output logic                           sounding,
	output logic [14:0]                    out_freq,
	output logic [6:0]                     out_duty_percent,
	output logic [9:0]                     pwm_level,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bps_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bps_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bps_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import bps_pkg::*;

	logic               valid_s1;
	op_t                op_s1;
	logic [15:0]        freq_s1, on_s1, gap_s1;
	logic [7:0]         rep_s1, duty_s1;
	logic               res_valid_q;
	res_t               res_q;
	logic               accept, adv;
	cfg_t               cfg;
	cmd_t               cmd;
	logic [LEVEL_W-1:0] level;
	res_t               res;

	// Handshake: stage advances when the result register is free or draining
	assign adv       = valid_s1 && (!res_valid_q || !res_stall);
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_t'(op);
			freq_s1 <= tone_freq;
			on_s1   <= on_time;
			gap_s1  <= gap_time;
			rep_s1  <= repeats;
			duty_s1 <= duty_percent;
		end
	end

	bps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bps_cmd #(
		.PWM_BITS (PWM_BITS)
	) u_cmd (
		.op           (op_s1),
		.tone_freq    (freq_s1),
		.on_time      (on_s1),
		.gap_time     (gap_s1),
		.repeats      (rep_s1),
		.duty_percent (duty_s1),
		.cfg          (cfg),
		.cmd          (cmd),
		.level        (level)
	);

	bps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.op     (op_s1),
		.cmd    (cmd),
		.level  (level),
		.enable (cfg.enable),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign res_valid        = res_valid_q;
	assign result_code      = res_q.code;
	assign sounding         = res_q.sounding;
	assign out_freq         = res_q.freq;
	assign out_duty_percent = res_q.duty;
	assign pwm_level        = res_q.level;

`ifndef SYNTHESIS
	a_silent_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.sounding
		|-> (res_q.freq == '0) && (res_q.duty == '0) && (res_q.level == '0))
		else $error("silent result carries tone fields");
`endif

endmodule

>>> bench/beep_sequence_monitor.sv
// Channel monitor, playback predictor and result checker for the beep pattern sequencer.
module beep_sequence_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_stall,
	input  logic [1:0]                     op,
	input  logic [15:0]                    tone_freq,
	input  logic [15:0]                    on_time,
	input  logic [15:0]                    gap_time,
	input  logic [7:0]                     repeats,
	input  logic [7:0]                     duty_percent,
	input  logic                           res_valid,
	input  logic                           res_stall,
	input  logic [1:0]                     result_code,
	input  logic                           sounding,
	input  logic [14:0]                    out_freq,
	input  logic [6:0]                     out_duty_percent,
	input  logic [9:0]                     pwm_level,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [bps_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bps_pkg::APB_DATA_W-1:0] pwdata,
	output int                             mismatch_count,
	output int                             results_owed,
	output int                             results_seen
);
	import bps_pkg::*;

	// register copies
	logic        buzz_en;
	logic [14:0] dflt_freq;
	logic [15:0] dflt_on;
	logic [15:0] dflt_gap;
	logic [6:0]  dflt_duty;

	// playback state
	phase_t      ph;
	logic [15:0] remain;
	logic [7:0]  periods_left;
	logic [14:0] cur_freq;
	logic [6:0]  cur_duty;
	logic [15:0] cur_on;
	logic [15:0] cur_gap;
	logic        looping;

	res_t        owed_q[$];
	int          fails = 0;
	int          seen  = 0;

	assign mismatch_count = fails;
	assign results_owed   = owed_q.size();
	assign results_seen   = seen;

	function automatic void stop_play();
		ph = PH_IDLE;
		remain = '0;
		periods_left = '0;
	endfunction

	// next on period of a pattern; fails to start when disabled
	function automatic void start_period();
		if (!buzz_en) begin
			stop_play();
		end else begin
			ph = PH_ON;
			remain = cur_on;
		end
	endfunction

	// one millisecond of playback
	function automatic void tick_play();
		if (ph != PH_ON && ph != PH_GAP)
			return;
		if (remain > 16'd1) begin
			remain = remain - 16'd1;
			return;
		end
		if (ph == PH_ON) begin
			if (looping && periods_left != 8'd0) begin
				ph = PH_GAP;
				remain = cur_gap;
			end else begin
				stop_play();
			end
		end else begin
			periods_left = periods_left - 8'd1;
			start_period();
		end
	endfunction

	// resolve defaults, range check, and restart playback on success
	function automatic rc_t start_command(logic is_pattern, logic [15:0] f_in,
			logic [15:0] on_in, logic [15:0] gap_in, logic [7:0] rep, logic [7:0] d_in);
		logic [15:0] f;
		logic [15:0] on_ms;
		logic [15:0] gp;
		logic [7:0]  d;
		f     = (f_in == 16'd0) ? 16'(dflt_freq) : f_in;
		on_ms = (on_in == 16'd0) ? dflt_on : on_in;
		gp    = (gap_in == 16'd0) ? dflt_gap : gap_in;
		d     = (d_in == 8'd0) ? 8'(dflt_duty) : d_in;
		if (!buzz_en)
			return RC_BAD_STATE;
		if (f < FREQ_MIN || f > FREQ_MAX || on_ms < TIME_MIN || on_ms > TIME_MAX
				|| d < DUTY_MIN || d > DUTY_MAX)
			return RC_BAD_ARG;
		if (is_pattern && (rep == 8'd0 || gp < TIME_MIN || gp > TIME_MAX))
			return RC_BAD_ARG;
		cur_freq = f[14:0];
		cur_duty = d[6:0];
		cur_on   = on_ms;
		if (is_pattern) begin
			cur_gap = gp;
			looping = 1'b1;
			periods_left = rep - 8'd1;
		end else begin
			cur_gap = '0;
			looping = 1'b0;
			periods_left = '0;
		end
		ph = PH_ON;
		remain = on_ms;
		return RC_OK;
	endfunction

	// apply one request and form the output it should produce
	function automatic res_t apply_request(op_t o);
		res_t r;
		int   lvl;
		r.code = RC_OK;
		case (o)
			OP_TICK: tick_play();
			OP_STOP: stop_play();
			default: r.code = start_command(o == OP_PATTERN, tone_freq, on_time, gap_time,
				repeats, duty_percent);
		endcase
		r.sounding = (ph == PH_ON);
		if (r.sounding) begin
			lvl = ((1 << LEVEL_W) - 1) * int'(cur_duty) / 100;
			if (lvl == 0)
				lvl = 1;
			r.freq  = cur_freq;
			r.duty  = cur_duty;
			r.level = lvl[LEVEL_W-1:0];
		end else begin
			r.freq  = '0;
			r.duty  = '0;
			r.level = '0;
		end
		return r;
	endfunction

	function automatic void report(string what, res_t want);
		fails++;
		if (fails <= 10)
			$display("%0t: %s: expected code %0d sounding %0d freq %0d duty %0d level %0d,",
				$realtime, what, want.code, want.sounding, want.freq, want.duty, want.level,
				" got code %0d sounding %0d freq %0d duty %0d level %0d",
				result_code, sounding, out_freq, out_duty_percent, pwm_level);
	endfunction

	// watch config writes, results and requests at each rising edge
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			buzz_en   = 1'b0;
			dflt_freq = FB_FREQ_RST;
			dflt_on   = FB_ON_RST;
			dflt_gap  = FB_GAP_RST;
			dflt_duty = FB_DUTY_RST;
			ph        = PH_IDLE;
			remain    = '0;
			periods_left = '0;
			cur_freq  = '0;
			cur_duty  = '0;
			cur_on    = '0;
			cur_gap   = '0;
			looping   = 1'b0;
			owed_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:2])
					REG_ENABLE:  buzz_en   = pwdata[0];
					REG_FB_FREQ: dflt_freq = pwdata[14:0];
					REG_FB_ON:   dflt_on   = pwdata[15:0];
					REG_FB_GAP:  dflt_gap  = pwdata[15:0];
					REG_FB_DUTY: dflt_duty = pwdata[6:0];
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				seen++;
				if (owed_q.size() == 0) begin
					report("result with no request outstanding", '0);
				end else begin
					want = owed_q.pop_front();
					if (want.code !== result_code || want.sounding !== sounding
							|| want.freq !== out_freq || want.duty !== out_duty_percent
							|| want.level !== pwm_level)
						report("result mismatch", want);
				end
			end
			if (req_valid && !req_stall)
				owed_q.push_back(apply_request(op_t'(op)));
		end
	end

endmodule

>>> bench/beep_pattern_sequencer_tb.sv
// Clock, reset, request and register stimulus, and verdict for the beep pattern sequencer.
module beep_pattern_sequencer_tb;
	import bps_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic [1:0]            op = OP_TICK;
	logic [15:0]           tone_freq = '0;
	logic [15:0]           on_time = '0;
	logic [15:0]           gap_time = '0;
	logic [7:0]            repeats = '0;
	logic [7:0]            duty_percent = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic [1:0]            result_code;
	logic                  sounding;
	logic [14:0]           out_freq;
	logic [6:0]            out_duty_percent;
	logic [9:0]            pwm_level;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int mismatches;
	int owed;
	int seen;
	int reqs_sent = 0;
	int settings_done = 0;
	bit send_calm = 1'b0;
	bit take_calm = 1'b0;

	beep_pattern_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .op(op), .tone_freq(tone_freq),
		.on_time(on_time), .gap_time(gap_time), .repeats(repeats),
		.duty_percent(duty_percent),
		.res_valid(res_valid), .res_stall(res_stall), .result_code(result_code),
		.sounding(sounding), .out_freq(out_freq), .out_duty_percent(out_duty_percent),
		.pwm_level(pwm_level),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	beep_sequence_monitor mon (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .op(op), .tone_freq(tone_freq),
		.on_time(on_time), .gap_time(gap_time), .repeats(repeats),
		.duty_percent(duty_percent),
		.res_valid(res_valid), .res_stall(res_stall), .result_code(result_code),
		.sounding(sounding), .out_freq(out_freq), .out_duty_percent(out_duty_percent),
		.pwm_level(pwm_level),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
		.pwdata(pwdata),
		.mismatch_count(mismatches), .results_owed(owed), .results_seen(seen)
	);

	always #6 clk = ~clk;

	function automatic int idle_cycles(bit calm);
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	// values around a valid range, plus the field extremes
	function automatic logic [15:0] near_limit(logic [15:0] lo, logic [15:0] hi);
		case ($urandom_range(0, 6))
			0: return lo - 16'd1;
			1: return lo;
			2: return hi;
			3: return hi + 16'd1;
			4: return 16'd0;
			5: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// result side: random stall before each result
	initial begin
		int n;
		forever begin
			n = idle_cycles(take_calm);
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// one request, after a random gap; returns at the falling edge after acceptance
	task automatic send_req(op_t o, logic [15:0] f, logic [15:0] on_ms, logic [15:0] gp,
			logic [7:0] rep, logic [7:0] d);
		int n;
		n = idle_cycles(send_calm);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		req_valid    <= 1'b1;
		op           <= o;
		tone_freq    <= f;
		on_time      <= on_ms;
		gap_time     <= gp;
		repeats      <= rep;
		duty_percent <= d;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
		reqs_sent++;
	endtask

	task automatic send_tick();
		send_req(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
			8'($urandom));
	endtask

	// hold off until every result is back, then let the pipeline settle
	task automatic quiesce();
		req_valid <= 1'b0;
		while (owed != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// register write; upper data bits carry junk that the block must drop
	task automatic write_reg(logic [2:0] idx, logic [31:0] val, int width);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= (32'($urandom) & ~32'((64'd1 << width) - 1)) | val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_settings(logic en, logic [14:0] f, logic [15:0] on_ms,
			logic [15:0] gp, logic [6:0] d);
		quiesce();
		write_reg(REG_ENABLE, 32'(en), 1);
		write_reg(REG_FB_FREQ, 32'(f), 15);
		write_reg(REG_FB_ON, 32'(on_ms), 16);
		write_reg(REG_FB_GAP, 32'(gp), 16);
		write_reg(REG_FB_DUTY, 32'(d), 7);
		settings_done++;
		send_calm = ($urandom_range(0, 3) == 0);
		take_calm = ($urandom_range(0, 3) == 0);
	endtask

	function automatic logic [15:0] short_ms();
		return ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(10, 25));
	endfunction

	// mostly commands followed by ticks that play them out, some raw noise
	task automatic play_burst(int count);
		int   goal;
		int   k;
		op_t  o;
		goal = reqs_sent + count;
		while (reqs_sent < goal) begin
			if ($urandom_range(0, 9) == 0) begin
				send_calm = ~send_calm;
				take_calm = ($urandom_range(0, 2) == 0);
			end
			if ($urandom_range(0, 199) == 0)
				quiesce();
			if ($urandom_range(0, 99) < 75) begin
				o = ($urandom_range(0, 2) != 0) ? OP_PATTERN : OP_TONE;
				send_req(o,
					($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(100, 20000)),
					short_ms(), short_ms(),
					($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(1, 4)),
					($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 90)));
				k = $urandom_range(4, 70);
				repeat (k) begin
					if ($urandom_range(0, 39) == 0)
						send_req(OP_STOP, 16'($urandom), 16'($urandom), 16'($urandom),
							8'($urandom), 8'($urandom));
					else
						send_tick();
				end
			end else if ($urandom_range(0, 1) == 0) begin
				send_req(op_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				send_req(op_t'($urandom_range(0, 3)), near_limit(FREQ_MIN, FREQ_MAX),
					near_limit(TIME_MIN, TIME_MAX), near_limit(TIME_MIN, TIME_MAX),
					8'(near_limit(16'd1, 16'd255)),
					8'(near_limit(16'(DUTY_MIN), 16'(DUTY_MAX))));
			end
		end
	endtask

	// main sequence
	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// disabled after reset: commands rejected, stop and tick still fine
		send_req(OP_TONE, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
		send_req(OP_PATTERN, 16'd440, 16'd20, 16'd20, 8'd2, 8'd30);
		send_tick();
		send_req(OP_STOP, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
		quiesce();
		write_reg(REG_ENABLE, 32'd1, 1);

		// reset defaults, range edges of each field
		send_req(OP_TONE, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
		send_req(OP_TONE, 16'd99, 16'd50, 16'd0, 8'd0, 8'd40);
		send_req(OP_TONE, 16'd20001, 16'd50, 16'd0, 8'd0, 8'd40);
		send_req(OP_TONE, 16'hFFFF, 16'd50, 16'd0, 8'd0, 8'd40);
		send_req(OP_TONE, 16'd1000, 16'd9, 16'd0, 8'd0, 8'd40);
		send_req(OP_TONE, 16'd1000, 16'd60001, 16'd0, 8'd0, 8'd40);
		send_req(OP_TONE, 16'd1000, 16'hFFFF, 16'd0, 8'd0, 8'd91);
		send_req(OP_TONE, 16'd1000, 16'd50, 16'd0, 8'd0, 8'd255);
		send_req(OP_PATTERN, 16'd1000, 16'd50, 16'd50, 8'd0, 8'd40);
		send_req(OP_PATTERN, 16'd1000, 16'd50, 16'd9, 8'd3, 8'd40);
		send_req(OP_PATTERN, 16'd1000, 16'd50, 16'd60001, 8'd3, 8'd40);
		// tone ignores gap and count
		send_req(OP_TONE, 16'd100, 16'd60000, 16'd9, 8'd0, 8'd1);
		send_req(OP_TONE, 16'd20000, 16'd10, 16'hFFFF, 8'd0, 8'd90);
		send_tick();
		// rejected request leaves the tone playing
		send_req(OP_PATTERN, 16'd500, 16'd10, 16'd10, 8'd0, 8'd20);
		send_tick();
		send_req(OP_PATTERN, 16'd20000, 16'd60000, 16'd60000, 8'd255, 8'd90);
		send_req(OP_PATTERN, 16'd100, 16'd10, 16'd10, 8'd1, 8'd1);
		repeat (3) send_tick();
		send_req(OP_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
		send_tick();

		// enable dropped in a pattern gap: next on period fails to start
		send_req(OP_PATTERN, 16'd3000, 16'd10, 16'd12, 8'd3, 8'd60);
		repeat (13) send_tick();
		quiesce();
		write_reg(REG_ENABLE, 32'd0, 1);
		repeat (14) send_tick();
		send_req(OP_TONE, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
		send_req(OP_STOP, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
		// enable dropped during an on period: that period still finishes
		quiesce();
		write_reg(REG_ENABLE, 32'd1, 1);
		send_req(OP_PATTERN, 16'd800, 16'd15, 16'd10, 8'd2, 8'd10);
		repeat (5) send_tick();
		quiesce();
		write_reg(REG_ENABLE, 32'd0, 1);
		repeat (30) send_tick();

		// random traffic under a range of register settings
		load_settings(1'b1, FB_FREQ_RST, FB_ON_RST, FB_GAP_RST, FB_DUTY_RST);
		play_burst(200);
		load_settings(1'b1, 15'd100, 16'd10, 16'd10, 7'd1);
		play_burst(200);
		load_settings(1'b1, 15'd20000, 16'd60000, 16'd60000, 7'd90);
		play_burst(170);
		load_settings(1'b1, 15'd99, 16'd9, 16'd9, 7'd0);
		play_burst(170);
		load_settings(1'b1, 15'h7FFF, 16'hFFFF, 16'd60001, 7'h7F);
		play_burst(170);
		load_settings(1'b0, 15'($urandom_range(100, 20000)), 16'($urandom_range(10, 30)),
			16'($urandom_range(10, 30)), 7'($urandom_range(1, 90)));
		play_burst(100);
		load_settings(1'b1, 15'($urandom_range(100, 20000)), 16'($urandom_range(10, 30)),
			16'($urandom_range(10, 30)), 7'($urandom_range(1, 90)));
		play_burst(180);
		load_settings(1'b1, FB_FREQ_RST, FB_ON_RST, FB_GAP_RST, FB_DUTY_RST);
		play_burst(180);

		quiesce();
		repeat (6) @(posedge clk);
		$display("run covered %0d requests and %0d results over %0d register settings",
			reqs_sent, seen, settings_done);
		$display("ticks, stop, tone and pattern, range edges, disable during playback");
		if (mismatches == 0 && owed == 0) begin
			$display("beep_pattern_sequencer verification clean");
		end else begin
			$display("beep_pattern_sequencer verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(12 * 400000);
		$display("beep_pattern_sequencer verification failed");
		$finish;
	end

endmodule

>>> files.f
hdl/bps_pkg.sv
hdl/bps_regs.sv
hdl/bps_cmd.sv
hdl/bps_seq.sv
hdl/beep_pattern_sequencer.sv
bench/beep_sequence_monitor.sv
bench/beep_pattern_sequencer_tb.sv
